@@ src/matrix_game_saddle_point_macros.svh @@
// Assertion macros for the matrix game saddle-point block.
// Included by the top level; relies on aclk and aresetn in scope.
`ifndef MATRIX_GAME_SADDLE_POINT_MACROS_SVH
`define MATRIX_GAME_SADDLE_POINT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define MGSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle
`define MGSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mgsp_pkg.sv @@
// Package for the matrix game saddle-point block: default sizes,
// field widths and configuration register indexes. No dependencies.
package mgsp_pkg;

    // Default sizes handed to the top-level parameters
    localparam int MAX_COLUMNS_DEF = 256;
    localparam int MAX_ROWS_DEF    = 256;
    localparam int VALUE_BITS_DEF  = 16;

    // Fixed field widths
    localparam int INDEX_BITS = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_ADDR_W = 1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLUMN_COUNT = 1'b1;

endpackage

@@ src/matrix_game_saddle_point.sv @@
// Matrix game saddle-point finder: maximin and minimax of a streamed matrix.
// Depends on mgsp_pkg and matrix_game_saddle_point_macros.svh.
//
// Usage:
//   Write row_count (index 0) and column_count (index 1) on the cfg port
//   while the block is idle; a count of zero acts as 1 and a count above the
//   parameter maximum acts as that maximum. Any write restarts the matrix.
//   Stream the payoff matrix on s_* in row-major order, one element per
//   transfer. After the final element one result transfer appears on m_*
//   with both indices, both values and the saddle flag; other elements give
//   no result. Then the next matrix begins.
// Throughput:
//   One element per cycle while no final element waits on a stalled result.
//   The column-maximum memory is read when an element is taken and written
//   back when it commits; m_tvalid is registered from the final commit.
//   Back-to-back visits to the same column are forwarded around the memory.
// Reset and stall:
//   aresetn (synchronous, active low) sets both counts to 1 and restarts at
//   row 0, column 0; the memory needs no clearing, since row 0 writes every
//   column before it is read. While a result waits on a stalled m_tready,
//   further elements are still taken until the next final element arrives.
module matrix_game_saddle_point #(
    parameter int MAX_COLUMNS = mgsp_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = mgsp_pkg::MAX_ROWS_DEF,
    parameter int VALUE_BITS  = mgsp_pkg::VALUE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // Configuration write port
    input  logic                                      cfg_wr_en,
    input  logic [mgsp_pkg::CFG_ADDR_W-1:0]           cfg_addr,
    input  logic [mgsp_pkg::CFG_DATA_W-1:0]           cfg_data,
    // Input stream
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // s_tdata: payoff
    input  logic [((VALUE_BITS+7)/8)*8-1:0]           s_tdata,
    // Result stream
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // m_tdata: best_row, maximin_value, best_column, minimax_value, has_saddle
    output logic [((2*mgsp_pkg::INDEX_BITS+2*VALUE_BITS+1+7)/8)*8-1:0] m_tdata
);

    localparam int COL_IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_CNT_W = COL_IDX_W + 1;
    localparam int ROW_CNT_W = ROW_IDX_W + 1;
    localparam int IDX_B     = mgsp_pkg::INDEX_BITS;
    localparam int M_TDATA_W = ((2*IDX_B + 2*VALUE_BITS + 1 + 7) / 8) * 8;

    // Configuration and position registers
    logic [ROW_CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [COL_CNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_IDX_W-1:0] row_pos_reg, row_pos_next;
    logic [COL_IDX_W-1:0] col_pos_reg, col_pos_next;

    // Second stage: element in flight
    logic                         s1_valid_reg, s1_valid_next;
    logic signed [VALUE_BITS-1:0] s1_payoff_reg;
    logic [ROW_IDX_W-1:0]         s1_row_reg;
    logic [COL_IDX_W-1:0]         s1_col_reg;
    logic                         s1_first_col_reg, s1_first_row_reg;
    logic                         s1_last_col_reg, s1_last_row_reg;

    // Column-maximum memory, read data and forwarding
    logic signed [VALUE_BITS-1:0] colmax_mem [MAX_COLUMNS];
    logic signed [VALUE_BITS-1:0] rd_data_reg;
    logic                         fwd_hit_reg;
    logic signed [VALUE_BITS-1:0] fwd_data_reg;

    // Running values
    logic signed [VALUE_BITS-1:0] row_min_reg, row_min_next;
    logic signed [VALUE_BITS-1:0] best_row_val_reg, best_row_val_next;
    logic [ROW_IDX_W-1:0]         best_row_idx_reg, best_row_idx_next;
    logic signed [VALUE_BITS-1:0] best_col_val_reg, best_col_val_next;
    logic [COL_IDX_W-1:0]         best_col_idx_reg, best_col_idx_next;

    // Output register
    logic                         m_valid_reg, m_valid_next;
    logic [IDX_B-1:0]             m_best_row_reg, m_best_col_reg;
    logic signed [VALUE_BITS-1:0] m_maximin_reg, m_minimax_reg;
    logic                         m_saddle_reg;

    logic                         accept;
    logic                         s1_last;
    logic                         s1_commit;
    logic                         last_col0, last_row0;
    logic signed [VALUE_BITS-1:0] payoff_in;
    logic signed [VALUE_BITS-1:0] colmax_old, colmax_new;
    logic [ROW_IDX_W+IDX_B-1:0]   row_idx_ext;
    logic [COL_IDX_W+IDX_B-1:0]   col_idx_ext;

    assign payoff_in = signed'(s_tdata[VALUE_BITS-1:0]);
    assign s1_last   = s1_last_col_reg && s1_last_row_reg;

    // Hold the element in flight only when its result cannot leave
    assign s1_commit = s1_valid_reg && !(s1_last && m_valid_reg && !m_tready);
    assign s_tready  = !s1_valid_reg || s1_commit;
    assign accept    = s_tvalid && s_tready;

    assign last_col0 = (COL_CNT_W'(col_pos_reg) + 1'b1) == col_cnt_reg;
    assign last_row0 = (ROW_CNT_W'(row_pos_reg) + 1'b1) == row_cnt_reg;

    // Clamp counts and advance the matrix position
    always_comb begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cfg_wr_en) begin
            row_pos_next = '0;
            col_pos_next = '0;
            case (cfg_addr)
                mgsp_pkg::CFG_ROW_COUNT: begin
                    if (cfg_data == '0) begin
                        row_cnt_next = ROW_CNT_W'(1);
                    end else if (int'(cfg_data) > MAX_ROWS) begin
                        row_cnt_next = ROW_CNT_W'(MAX_ROWS);
                    end else begin
                        row_cnt_next = ROW_CNT_W'(cfg_data);
                    end
                end
                mgsp_pkg::CFG_COLUMN_COUNT: begin
                    if (cfg_data == '0) begin
                        col_cnt_next = COL_CNT_W'(1);
                    end else if (int'(cfg_data) > MAX_COLUMNS) begin
                        col_cnt_next = COL_CNT_W'(MAX_COLUMNS);
                    end else begin
                        col_cnt_next = COL_CNT_W'(cfg_data);
                    end
                end
                default: begin
                    row_cnt_next = row_cnt_reg;
                end
            endcase
        end else if (accept) begin
            if (last_col0) begin
                col_pos_next = '0;
                row_pos_next = last_row0 ? '0 : row_pos_reg + 1'b1;
            end else begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
    end

    // Update column maximum, row minimum, maximin and minimax
    always_comb begin
        colmax_old = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        if (s1_first_row_reg || s1_payoff_reg > colmax_old) begin
            colmax_new = s1_payoff_reg;
        end else begin
            colmax_new = colmax_old;
        end

        if (s1_first_col_reg || s1_payoff_reg < row_min_reg) begin
            row_min_next = s1_payoff_reg;
        end else begin
            row_min_next = row_min_reg;
        end

        best_col_val_next = best_col_val_reg;
        best_col_idx_next = best_col_idx_reg;
        if (s1_last_row_reg && (s1_first_col_reg || colmax_new < best_col_val_reg)) begin
            best_col_val_next = colmax_new;
            best_col_idx_next = s1_col_reg;
        end

        best_row_val_next = best_row_val_reg;
        best_row_idx_next = best_row_idx_reg;
        if (s1_last_col_reg && (s1_first_row_reg || row_min_next > best_row_val_reg)) begin
            best_row_val_next = row_min_next;
            best_row_idx_next = s1_row_reg;
        end
    end

    assign row_idx_ext = {IDX_B'(0), best_row_idx_next};
    assign col_idx_ext = {IDX_B'(0), best_col_idx_next};

    // Stage and output handshake
    always_comb begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_commit) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_commit && s1_last) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg  <= ROW_CNT_W'(1);
            col_cnt_reg  <= COL_CNT_W'(1);
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (accept) begin
                fwd_hit_reg <= s1_commit && (s1_col_reg == col_pos_reg);
            end
        end
    end

    // Column-maximum memory: read on transfer, write back on commit
    always_ff @(posedge aclk) begin
        if (s1_commit) begin
            colmax_mem[s1_col_reg] <= colmax_new;
        end
        if (accept) begin
            rd_data_reg <= colmax_mem[col_pos_reg];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            fwd_data_reg     <= colmax_new;
            s1_payoff_reg    <= payoff_in;
            s1_row_reg       <= row_pos_reg;
            s1_col_reg       <= col_pos_reg;
            s1_first_col_reg <= (col_pos_reg == '0);
            s1_first_row_reg <= (row_pos_reg == '0);
            s1_last_col_reg  <= last_col0;
            s1_last_row_reg  <= last_row0;
        end
        if (s1_commit) begin
            row_min_reg      <= row_min_next;
            best_row_val_reg <= best_row_val_next;
            best_row_idx_reg <= best_row_idx_next;
            best_col_val_reg <= best_col_val_next;
            best_col_idx_reg <= best_col_idx_next;
        end
        if (s1_commit && s1_last) begin
            m_best_row_reg <= row_idx_ext[IDX_B-1:0];
            m_maximin_reg  <= best_row_val_next;
            m_best_col_reg <= col_idx_ext[IDX_B-1:0];
            m_minimax_reg  <= best_col_val_next;
            m_saddle_reg   <= (best_row_val_next == best_col_val_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_saddle_reg, m_minimax_reg, m_best_col_reg,
                                  m_maximin_reg, m_best_row_reg});

    // Assertions
`include "matrix_game_saddle_point_macros.svh"

    `MGSP_ASSERT_SAME(a_hold_only_on_result, s1_valid_reg && !s1_commit, s1_last && m_valid_reg, "element held without a blocked result")
    `MGSP_ASSERT_NEXT(a_result_follows_last, s1_commit && s1_last, m_valid_reg, "final element gave no result")
    `MGSP_ASSERT_SAME(a_saddle_flag, m_valid_reg, m_saddle_reg == (m_maximin_reg == m_minimax_reg), "saddle flag disagrees with values")

endmodule
